// ===== rtl/sbc_pkg.sv =====
// Shared constants and types for the swept box collision block.
// Used by swept_box_collision and its divider pipeline sbc_div_pipe.
package sbc_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int WORD_BITS_DEF = 32;
  localparam int DT_BITS       = 18;
  localparam int TIME_BITS     = 64;

  localparam logic [DT_BITS-1:0]   DT_RESET = 18'd1092;
  localparam logic [TIME_BITS-1:0] TIME_MAX = 64'h3FFF_FFFF_FFFF_FFFF;
  localparam logic [TIME_BITS-1:0] TIME_INF = 64'h4000_0000_0000_0000;
  localparam logic [TIME_BITS-1:0] TIME_NEG_INF = 64'hC000_0000_0000_0000;

  // Two-bit signed normal codes
  localparam logic [1:0] NORM_ZERO = 2'b00;
  localparam logic [1:0] NORM_POS  = 2'b01;
  localparam logic [1:0] NORM_NEG  = 2'b11;

  // Per-axis flags that ride along with the slab divisions
  typedef struct packed {
    logic kill;    // both velocity components zero
    logic dneg;    // motion along this axis is negative
    logic dzero;   // scaled direction is zero on this axis
    logic in_slab; // start lies within the widened slab
    logic lo_neg;  // low-edge numerator is negative
    logic hi_neg;  // high-edge numerator is negative
  } axis_flags_t;

endpackage

// ===== rtl/swept_box_collision.sv =====
// Swept box collision top level: front end, two slab divider pipelines, back end.
// Depends on sbc_pkg and sbc_div_pipe.
//
// One moving box (centre, size, velocity) is tested against one target box per
// transfer; a transfer is taken on any clock edge with start high and busy low,
// so a new box pair may enter on every cycle. busy is high only during reset
// and in the cycle after it. Every transfer yields exactly one result, shown
// for one cycle with out_valid high. The restoring slab divider resolves one
// quotient bit per pipeline stage (Q16.16 in 32-bit words by default). The
// receiver cannot hold results off: capture them on the out_valid cycle.
// delta_time is written through the cfg_ channel (always ready) and must only
// change while no transfer is in flight.
module swept_box_collision #(
  parameter int FRAC_BITS = sbc_pkg::FRAC_BITS_DEF,
  parameter int WORD_BITS = sbc_pkg::WORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [WORD_BITS-1:0]   in_box_x,
  input  logic signed [WORD_BITS-1:0]   in_box_y,
  input  logic [WORD_BITS-2:0]          in_box_width,
  input  logic [WORD_BITS-2:0]          in_box_height,
  input  logic signed [WORD_BITS-1:0]   in_target_x,
  input  logic signed [WORD_BITS-1:0]   in_target_y,
  input  logic [WORD_BITS-2:0]          in_target_width,
  input  logic [WORD_BITS-2:0]          in_target_height,
  input  logic signed [WORD_BITS-1:0]   in_vel_x,
  input  logic signed [WORD_BITS-1:0]   in_vel_y,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sbc_pkg::DT_BITS-1:0]   cfg_delta_time,
  output logic                          out_valid,
  output logic                          out_collided,
  output logic signed [1:0]             out_normal_x,
  output logic signed [1:0]             out_normal_y,
  output logic signed [WORD_BITS-1:0]   out_contact_time,
  output logic signed [WORD_BITS-1:0]   out_penetration_depth
);

  localparam int W   = WORD_BITS;
  localparam int DTB = sbc_pkg::DT_BITS;
  localparam int PW  = W + DTB;           // velocity times step
  localparam int DW  = PW - FRAC_BITS;    // scaled direction magnitude
  localparam int NW  = W + 2;             // signed edge-to-centre distance
  localparam int MW  = W + 1;             // its magnitude
  localparam int QW  = MW + FRAC_BITS;    // slab time quotient
  localparam int TB  = sbc_pkg::TIME_BITS;
  localparam int BACK_LAT = QW + 4;       // divider entry to result

  localparam logic [TB-1:0] T_ONE  = TB'(1) << FRAC_BITS;
  localparam logic [TB-1:0] CT_MIN = ~((TB'(1) << (W - 1)) - TB'(1));

  // Saturate a W+2 bit two's complement value to W bits
  function automatic logic [W-1:0] sat_word(input logic [W+1:0] v);
    logic all0, all1;
    all0 = (v[W+1:W-1] == 3'b000);
    all1 = (v[W+1:W-1] == 3'b111);
    if (all0 || all1) begin
      return v[W-1:0];
    end
    return v[W+1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
  endfunction

  // Saturate a quotient to the time range and apply the slab sign
  function automatic logic [TB-1:0] slab_time(input logic [QW-1:0] q, input logic neg);
    logic [QW+TB-1:0] qx;
    logic [TB-1:0]    m;
    qx = {{TB{1'b0}}, q};
    m  = (qx > (QW+TB)'(sbc_pkg::TIME_MAX)) ? sbc_pkg::TIME_MAX : qx[TB-1:0];
    return neg ? (~m + 1'b1) : m;
  endfunction

  // ---------------------------------------------------------------------------
  // Control: busy after reset, config register
  // ---------------------------------------------------------------------------
  logic           busy_r;
  logic [DTB-1:0] dt_r;
  logic           in_xfer;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy      = busy_r;
  assign cfg_ready = 1'b1;
  assign in_xfer   = start && !busy_r;

  // Hold the step until a config transfer replaces it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dt_r <= sbc_pkg::DT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      dt_r <= cfg_delta_time;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: velocity magnitude times step (one multiplier per axis)
  // ---------------------------------------------------------------------------
  logic [W-1:0] b0 [2];
  logic [W-1:0] t0 [2];
  logic [W-1:0] v0 [2];
  logic [W-2:0] bs0 [2];
  logic [W-2:0] ts0 [2];
  logic [W-1:0] vmag0 [2];

  assign b0[0]  = in_box_x;
  assign b0[1]  = in_box_y;
  assign t0[0]  = in_target_x;
  assign t0[1]  = in_target_y;
  assign v0[0]  = in_vel_x;
  assign v0[1]  = in_vel_y;
  assign bs0[0] = in_box_width;
  assign bs0[1] = in_box_height;
  assign ts0[0] = in_target_width;
  assign ts0[1] = in_target_height;

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      vmag0[a] = v0[a][W-1] ? (~v0[a] + 1'b1) : v0[a];
    end
  end

  logic          s1_vld_r;
  logic          s1_kill_r;
  logic [PW-1:0] s1_prod_r [2];
  logic          s1_vneg_r [2];
  logic [W-1:0]  s1_t_r [2];
  logic [W-1:0]  s1_b_r [2];
  logic [W-2:0]  s1_ts_r [2];
  logic [W-2:0]  s1_bs_r [2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_xfer;
    end
  end

  always_ff @(posedge clk) begin
    s1_kill_r <= (v0[0] == '0) && (v0[1] == '0);
    for (int a = 0; a < 2; a++) begin
      s1_prod_r[a] <= PW'(vmag0[a]) * PW'(dt_r);
      s1_vneg_r[a] <= v0[a][W-1];
      s1_t_r[a]    <= t0[a];
      s1_b_r[a]    <= b0[a];
      s1_ts_r[a]   <= ts0[a];
      s1_bs_r[a]   <= bs0[a];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: widen the target, slab edges, penetration terms
  // ---------------------------------------------------------------------------
  logic [W-1:0]  s2_ww [2];
  logic [W:0]    s2_lo_nxt [2];
  logic [W:0]    s2_hi_nxt [2];
  logic [W:0]    s2_diff_nxt [2];
  logic [W-2:0]  s2_hs_nxt [2];

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      s2_ww[a]       = {1'b0, s1_ts_r[a]} + {1'b0, s1_bs_r[a]};
      // left edge = t - floor(W/2); right edge = left + W = t + ceil(W/2)
      s2_lo_nxt[a]   = {s1_t_r[a][W-1], s1_t_r[a]} - {2'b00, s2_ww[a][W-1:1]};
      s2_hi_nxt[a]   = {s1_t_r[a][W-1], s1_t_r[a]} + {2'b00, s2_ww[a][W-1:1]}
                       + {{W{1'b0}}, s2_ww[a][0]};
      s2_diff_nxt[a] = {s1_t_r[a][W-1], s1_t_r[a]} - {s1_b_r[a][W-1], s1_b_r[a]};
      s2_hs_nxt[a]   = {1'b0, s1_ts_r[a][W-2:1]} + {1'b0, s1_bs_r[a][W-2:1]};
    end
  end

  logic          s2_vld_r;
  logic          s2_kill_r;
  logic [DW-1:0] s2_dir_r [2];
  logic          s2_vneg_r [2];
  logic [W:0]    s2_lo_r [2];
  logic [W:0]    s2_hi_r [2];
  logic [W-1:0]  s2_b_r [2];
  logic [W:0]    s2_diff_r [2];
  logic [W-2:0]  s2_hs_r [2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_kill_r <= s1_kill_r;
    for (int a = 0; a < 2; a++) begin
      s2_dir_r[a]  <= s1_prod_r[a][PW-1:FRAC_BITS];
      s2_vneg_r[a] <= s1_vneg_r[a];
      s2_lo_r[a]   <= s2_lo_nxt[a];
      s2_hi_r[a]   <= s2_hi_nxt[a];
      s2_b_r[a]    <= s1_b_r[a];
      s2_diff_r[a] <= s2_diff_nxt[a];
      s2_hs_r[a]   <= s2_hs_nxt[a];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: edge-to-centre distances, saturated penetration candidates
  // ---------------------------------------------------------------------------
  logic [NW-1:0] s3_nlo_nxt [2];
  logic [NW-1:0] s3_nhi_nxt [2];
  logic [W+1:0]  s3_pn_sum [2];
  logic [W+1:0]  s3_pp_sum [2];

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      s3_nlo_nxt[a] = {s2_lo_r[a][W], s2_lo_r[a]}
                      - {s2_b_r[a][W-1], s2_b_r[a][W-1], s2_b_r[a]};
      s3_nhi_nxt[a] = {s2_hi_r[a][W], s2_hi_r[a]}
                      - {s2_b_r[a][W-1], s2_b_r[a][W-1], s2_b_r[a]};
      // negative normal: (t + ts/2) - (b - bs/2); positive: (b + bs/2) - (t - ts/2)
      s3_pn_sum[a]  = {s2_diff_r[a][W], s2_diff_r[a]} + {3'b000, s2_hs_r[a]};
      s3_pp_sum[a]  = {3'b000, s2_hs_r[a]} - {s2_diff_r[a][W], s2_diff_r[a]};
    end
  end

  logic          s3_vld_r;
  logic          s3_kill_r;
  logic [DW-1:0] s3_dir_r [2];
  logic          s3_vneg_r [2];
  logic [NW-1:0] s3_nlo_r [2];
  logic [NW-1:0] s3_nhi_r [2];
  logic [W-1:0]  s3_pn_r [2];
  logic [W-1:0]  s3_pp_r [2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s3_kill_r <= s2_kill_r;
    for (int a = 0; a < 2; a++) begin
      s3_dir_r[a]  <= s2_dir_r[a];
      s3_vneg_r[a] <= s2_vneg_r[a];
      s3_nlo_r[a]  <= s3_nlo_nxt[a];
      s3_nhi_r[a]  <= s3_nhi_nxt[a];
      s3_pn_r[a]   <= sat_word(s3_pn_sum[a]);
      s3_pp_r[a]   <= sat_word(s3_pp_sum[a]);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: magnitudes and slab flags for the dividers
  // ---------------------------------------------------------------------------
  logic [NW-1:0]        s4_neg_lo [2];
  logic [NW-1:0]        s4_neg_hi [2];
  sbc_pkg::axis_flags_t s4_flags_nxt [2];

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      s4_neg_lo[a] = ~s3_nlo_r[a] + 1'b1;
      s4_neg_hi[a] = ~s3_nhi_r[a] + 1'b1;
      s4_flags_nxt[a].kill    = s3_kill_r;
      s4_flags_nxt[a].dneg    = s3_vneg_r[a];
      s4_flags_nxt[a].dzero   = (s3_dir_r[a] == '0);
      // left <= centre <= right, both bounds inclusive
      s4_flags_nxt[a].in_slab = (s3_nlo_r[a][NW-1] || (s3_nlo_r[a] == '0))
                                && !s3_nhi_r[a][NW-1];
      s4_flags_nxt[a].lo_neg  = s3_nlo_r[a][NW-1];
      s4_flags_nxt[a].hi_neg  = s3_nhi_r[a][NW-1];
    end
  end

  logic                 s4_vld_r;
  sbc_pkg::axis_flags_t s4_flags_r [2];
  logic [MW-1:0]        s4_mag_lo_r [2];
  logic [MW-1:0]        s4_mag_hi_r [2];
  logic [DW-1:0]        s4_dir_r [2];
  logic [W-1:0]         s4_pn_r [2];
  logic [W-1:0]         s4_pp_r [2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else begin
      s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < 2; a++) begin
      s4_flags_r[a]  <= s4_flags_nxt[a];
      s4_mag_lo_r[a] <= s3_nlo_r[a][NW-1] ? s4_neg_lo[a][MW-1:0] : s3_nlo_r[a][MW-1:0];
      s4_mag_hi_r[a] <= s3_nhi_r[a][NW-1] ? s4_neg_hi[a][MW-1:0] : s3_nhi_r[a][MW-1:0];
      s4_dir_r[a]    <= s3_dir_r[a];
      s4_pn_r[a]     <= s3_pn_r[a];
      s4_pp_r[a]     <= s3_pp_r[a];
    end
  end

  // ---------------------------------------------------------------------------
  // Slab dividers: distance * 2^FRAC_BITS / direction, one per axis
  // ---------------------------------------------------------------------------
  logic                 dv_vld [2];
  sbc_pkg::axis_flags_t dv_flags [2];
  logic [QW-1:0]        dv_qlo [2];
  logic [QW-1:0]        dv_qhi [2];

  for (genvar a = 0; a < 2; a++) begin : g_div
    sbc_div_pipe #(
      .NUM_W     (MW),
      .DEN_W     (DW),
      .FRAC_BITS (FRAC_BITS)
    ) u_div (
      .clk        (clk),
      .rst_n      (rst_n),
      .in_valid   (s4_vld_r),
      .in_flags   (s4_flags_r[a]),
      .in_num_lo  (s4_mag_lo_r[a]),
      .in_num_hi  (s4_mag_hi_r[a]),
      .in_den     (s4_dir_r[a]),
      .out_valid  (dv_vld[a]),
      .out_flags  (dv_flags[a]),
      .out_quo_lo (dv_qlo[a]),
      .out_quo_hi (dv_qhi[a])
    );
  end

  // Delay the penetration candidates to line up with the quotients
  logic [W-1:0] pd_n_r [QW][2];
  logic [W-1:0] pd_p_r [QW][2];

  always_ff @(posedge clk) begin
    for (int a = 0; a < 2; a++) begin
      pd_n_r[0][a] <= s4_pn_r[a];
      pd_p_r[0][a] <= s4_pp_r[a];
      for (int k = 1; k < QW; k++) begin
        pd_n_r[k][a] <= pd_n_r[k-1][a];
        pd_p_r[k][a] <= pd_p_r[k-1][a];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Back stage 1: signed, saturated slab times; infinite slab on zero direction
  // ---------------------------------------------------------------------------
  logic                 p1_vld_r;
  sbc_pkg::axis_flags_t p1_flags_r [2];
  logic [TB-1:0]        p1_ta_r [2];
  logic [TB-1:0]        p1_tb_r [2];
  logic [W-1:0]         p1_pn_r [2];
  logic [W-1:0]         p1_pp_r [2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
    end else begin
      p1_vld_r <= dv_vld[0];
    end
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < 2; a++) begin
      p1_flags_r[a] <= dv_flags[a];
      p1_pn_r[a]    <= pd_n_r[QW-1][a];
      p1_pp_r[a]    <= pd_p_r[QW-1][a];
      if (dv_flags[a].dzero) begin
        p1_ta_r[a] <= sbc_pkg::TIME_NEG_INF;
        p1_tb_r[a] <= sbc_pkg::TIME_INF;
      end else begin
        p1_ta_r[a] <= slab_time(dv_qlo[a], dv_flags[a].lo_neg != dv_flags[a].dneg);
        p1_tb_r[a] <= slab_time(dv_qhi[a], dv_flags[a].hi_neg != dv_flags[a].dneg);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Back stage 2: order each slab into near and far
  // ---------------------------------------------------------------------------
  logic                 p2_vld_r;
  sbc_pkg::axis_flags_t p2_flags_r [2];
  logic [TB-1:0]        p2_near_r [2];
  logic [TB-1:0]        p2_far_r [2];
  logic [W-1:0]         p2_pn_r [2];
  logic [W-1:0]         p2_pp_r [2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_vld_r <= 1'b0;
    end else begin
      p2_vld_r <= p1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < 2; a++) begin
      p2_flags_r[a] <= p1_flags_r[a];
      p2_pn_r[a]    <= p1_pn_r[a];
      p2_pp_r[a]    <= p1_pp_r[a];
      if ($signed(p1_ta_r[a]) < $signed(p1_tb_r[a])) begin
        p2_near_r[a] <= p1_ta_r[a];
        p2_far_r[a]  <= p1_tb_r[a];
      end else begin
        p2_near_r[a] <= p1_tb_r[a];
        p2_far_r[a]  <= p1_ta_r[a];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Back stage 3: slab overlap, entry and exit times, normal axis
  // ---------------------------------------------------------------------------
  logic p3_miss_nxt;

  always_comb begin
    p3_miss_nxt = p2_flags_r[0].kill || p2_flags_r[1].kill
                  || (p2_flags_r[0].dzero && !p2_flags_r[0].in_slab)
                  || (p2_flags_r[1].dzero && !p2_flags_r[1].in_slab)
                  || ($signed(p2_near_r[0]) > $signed(p2_far_r[1]))
                  || ($signed(p2_near_r[1]) > $signed(p2_far_r[0]));
  end

  logic          p3_vld_r;
  logic          p3_miss_r;
  logic          p3_xgt_r;
  logic          p3_ygt_r;
  logic          p3_nxneg_r;
  logic          p3_nyneg_r;
  logic [TB-1:0] p3_tn_r;
  logic [TB-1:0] p3_tf_r;
  logic [W-1:0]  p3_penx_r;
  logic [W-1:0]  p3_peny_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p3_vld_r <= 1'b0;
    end else begin
      p3_vld_r <= p2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    p3_miss_r  <= p3_miss_nxt;
    p3_xgt_r   <= $signed(p2_near_r[0]) > $signed(p2_near_r[1]);
    p3_ygt_r   <= $signed(p2_near_r[1]) > $signed(p2_near_r[0]);
    p3_nxneg_r <= p2_flags_r[0].dneg && !p2_flags_r[0].dzero;
    p3_nyneg_r <= p2_flags_r[1].dneg && !p2_flags_r[1].dzero;
    p3_tn_r    <= ($signed(p2_near_r[0]) > $signed(p2_near_r[1])) ? p2_near_r[0]
                                                                   : p2_near_r[1];
    p3_tf_r    <= ($signed(p2_far_r[0]) < $signed(p2_far_r[1])) ? p2_far_r[0]
                                                                : p2_far_r[1];
    // pick the penetration side by direction of motion on each axis
    p3_penx_r  <= (p2_flags_r[0].dneg && !p2_flags_r[0].dzero) ? p2_pn_r[0] : p2_pp_r[0];
    p3_peny_r  <= (p2_flags_r[1].dneg && !p2_flags_r[1].dzero) ? p2_pn_r[1] : p2_pp_r[1];
  end

  // ---------------------------------------------------------------------------
  // Back stage 4: hit window, normal, result registers
  // ---------------------------------------------------------------------------
  logic       p4_miss;
  logic [1:0] p4_nx, p4_ny;

  always_comb begin
    // drop exits before the step start and entries at or after its end
    p4_miss = p3_miss_r || p3_tf_r[TB-1] || ($signed(p3_tn_r) >= $signed(T_ONE));
    p4_nx   = sbc_pkg::NORM_ZERO;
    p4_ny   = sbc_pkg::NORM_ZERO;
    if (p3_xgt_r) begin
      p4_nx = p3_nxneg_r ? sbc_pkg::NORM_NEG : sbc_pkg::NORM_POS;
    end else if (p3_ygt_r) begin
      p4_ny = p3_nyneg_r ? sbc_pkg::NORM_NEG : sbc_pkg::NORM_POS;
    end
  end

  logic         out_valid_r;
  logic         out_collided_r;
  logic [1:0]   out_normal_x_r;
  logic [1:0]   out_normal_y_r;
  logic [W-1:0] out_contact_time_r;
  logic [W-1:0] out_pen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= p3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (p4_miss) begin
      out_collided_r     <= 1'b0;
      out_normal_x_r     <= sbc_pkg::NORM_ZERO;
      out_normal_y_r     <= sbc_pkg::NORM_ZERO;
      out_contact_time_r <= '0;
      out_pen_r          <= '0;
    end else begin
      out_collided_r     <= 1'b1;
      out_normal_x_r     <= p4_nx;
      out_normal_y_r     <= p4_ny;
      out_contact_time_r <= ($signed(p3_tn_r) < $signed(CT_MIN)) ? CT_MIN[W-1:0]
                                                                 : p3_tn_r[W-1:0];
      // tie of entry times: zero normal, zero depth
      out_pen_r          <= p3_xgt_r ? p3_penx_r : (p3_ygt_r ? p3_peny_r : '0);
    end
  end

  assign out_valid             = out_valid_r;
  assign out_collided          = out_collided_r;
  assign out_normal_x          = out_normal_x_r;
  assign out_normal_y          = out_normal_y_r;
  assign out_contact_time      = out_contact_time_r;
  assign out_penetration_depth = out_pen_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_div_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    dv_vld[0] == dv_vld[1])
    else $error("x and y slab dividers out of step");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    s4_vld_r |-> ##(BACK_LAT) out_valid_r)
    else $error("result missing after divider entry");

  a_one_normal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_collided_r |->
      !(out_normal_x_r != sbc_pkg::NORM_ZERO && out_normal_y_r != sbc_pkg::NORM_ZERO))
    else $error("normal set on both axes");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_collided_r |->
      out_normal_x_r == sbc_pkg::NORM_ZERO && out_normal_y_r == sbc_pkg::NORM_ZERO
      && out_contact_time_r == '0 && out_pen_r == '0)
    else $error("miss result carries nonzero fields");

  a_contact_below_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_collided_r |->
      $signed(out_contact_time_r) < $signed(W'(1) << FRAC_BITS))
    else $error("contact time at or past end of step");

endmodule

// ===== rtl/sbc_div_pipe.sv =====
// Pipelined restoring divider, one quotient bit per stage, two numerators
// over one shared denominator. Depends on sbc_pkg for the flag type.
module sbc_div_pipe #(
  parameter int NUM_W     = 33,
  parameter int DEN_W     = 34,
  parameter int FRAC_BITS = sbc_pkg::FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  sbc_pkg::axis_flags_t  in_flags,
  input  logic [NUM_W-1:0]      in_num_lo,
  input  logic [NUM_W-1:0]      in_num_hi,
  input  logic [DEN_W-1:0]      in_den,
  output logic                  out_valid,
  output sbc_pkg::axis_flags_t  out_flags,
  output logic [NUM_W+FRAC_BITS-1:0] out_quo_lo,
  output logic [NUM_W+FRAC_BITS-1:0] out_quo_hi
);

  localparam int QW = NUM_W + FRAC_BITS;

  logic                 vld_r    [QW];
  sbc_pkg::axis_flags_t flags_r  [QW];
  logic [DEN_W-1:0]     den_r    [QW];
  logic [DEN_W-1:0]     rem_lo_r [QW];
  logic [DEN_W-1:0]     rem_hi_r [QW];
  // Dividend bits shift out at the top while quotient bits shift in below
  logic [QW-1:0]        qd_lo_r  [QW];
  logic [QW-1:0]        qd_hi_r  [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic                 v_i;
    sbc_pkg::axis_flags_t f_i;
    logic [DEN_W-1:0]     den_i, rlo_i, rhi_i;
    logic [QW-1:0]        qlo_i, qhi_i;
    logic [DEN_W:0]       trial_lo, trial_hi, diff_lo, diff_hi;
    logic                 ge_lo, ge_hi;
    logic [DEN_W-1:0]     rem_lo_nxt, rem_hi_nxt;
    logic [QW-1:0]        qd_lo_nxt, qd_hi_nxt;

    if (k == 0) begin : g_first
      assign v_i   = in_valid;
      assign f_i   = in_flags;
      assign den_i = in_den;
      assign rlo_i = '0;
      assign rhi_i = '0;
      assign qlo_i = {in_num_lo, {FRAC_BITS{1'b0}}};
      assign qhi_i = {in_num_hi, {FRAC_BITS{1'b0}}};
    end else begin : g_next
      assign v_i   = vld_r[k-1];
      assign f_i   = flags_r[k-1];
      assign den_i = den_r[k-1];
      assign rlo_i = rem_lo_r[k-1];
      assign rhi_i = rem_hi_r[k-1];
      assign qlo_i = qd_lo_r[k-1];
      assign qhi_i = qd_hi_r[k-1];
    end

    always_comb begin
      trial_lo   = {rlo_i, qlo_i[QW-1]};
      trial_hi   = {rhi_i, qhi_i[QW-1]};
      diff_lo    = trial_lo - {1'b0, den_i};
      diff_hi    = trial_hi - {1'b0, den_i};
      ge_lo      = trial_lo >= {1'b0, den_i};
      ge_hi      = trial_hi >= {1'b0, den_i};
      rem_lo_nxt = ge_lo ? diff_lo[DEN_W-1:0] : trial_lo[DEN_W-1:0];
      rem_hi_nxt = ge_hi ? diff_hi[DEN_W-1:0] : trial_hi[DEN_W-1:0];
      qd_lo_nxt  = {qlo_i[QW-2:0], ge_lo};
      qd_hi_nxt  = {qhi_i[QW-2:0], ge_hi};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      flags_r[k]  <= f_i;
      den_r[k]    <= den_i;
      rem_lo_r[k] <= rem_lo_nxt;
      rem_hi_r[k] <= rem_hi_nxt;
      qd_lo_r[k]  <= qd_lo_nxt;
      qd_hi_r[k]  <= qd_hi_nxt;
    end
  end

  assign out_valid  = vld_r[QW-1];
  assign out_flags  = flags_r[QW-1];
  assign out_quo_lo = qd_lo_r[QW-1];
  assign out_quo_hi = qd_hi_r[QW-1];

endmodule
